// ===== rtl/crc_checked_page_receiver_assert.svh =====
// Assertion macros used by the checker file of the page receiver.
`ifndef CRC_CHECKED_PAGE_RECEIVER_ASSERT_SVH
`define CRC_CHECKED_PAGE_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CPR_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CPR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/crcpr_pkg.sv =====
// Package: constants, types and the CRC step of the page receiver.
package crcpr_pkg;

  localparam int PAGE_BYTES = 512;
  localparam int MAX_PAGES  = 64;
  localparam int CNT_W      = $clog2(PAGE_BYTES + 2);
  localparam int PG_W       = 6;
  localparam int LIM_W      = 7;
  localparam int GRP_SZ     = 8;
  localparam int OFF_W      = $clog2(GRP_SZ);
  localparam int NGRP       = MAX_PAGES / GRP_SZ;
  localparam int GRP_W      = $clog2(NGRP);

  localparam logic [LIM_W-1:0] TP_RESET = LIM_W'(MAX_PAGES);
  localparam logic [15:0]      CRC_POLY = 16'h1021;

  typedef enum logic [1:0] {
    K_OK   = 2'd0,
    K_BAD  = 2'd1,
    K_REQ  = 2'd2,
    K_DONE = 2'd3
  } kind_t;

  // front -> back event
  typedef struct packed {
    logic start;
    logic good;
  } ev_t;

  // back -> front verdict status
  typedef struct packed {
    logic valid;
    logic active;
  } resp_t;

  typedef struct packed {
    kind_t           kind;
    logic [PG_W-1:0] page;
    logic            last;
  } res_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/crcpr_queue.sv =====
// Two-entry event queue between the byte front end and the page sequencer.
module crcpr_queue
  import crcpr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ev_t  push_ev,
  output logic full,
  input  logic pop,
  output ev_t  pop_ev,
  output logic empty
);

  ev_t        mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full   = (cnt_r == 2'd2);
  assign empty  = (cnt_r == 2'd0);
  assign pop_ev = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/crcpr_front.sv =====
// Front end: takes bytes, runs the page CRC and posts start and page-end events.
module crcpr_front
  import crcpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_data_byte,
  input  logic       q_full,
  output logic       q_push,
  output ev_t        q_ev,
  input  resp_t      resp
);

  logic             active_r;
  logic             wait_r;
  logic [CNT_W-1:0] cnt_r;
  logic [15:0]      crc_r;
  logic [7:0]       lowb_r;
  logic             acc;
  logic             page_end;

  assign in_stall = wait_r | q_full;
  assign acc      = in_valid & ~in_stall;
  assign page_end = acc & ~in_mode & active_r & (cnt_r > CNT_W'(PAGE_BYTES));

  assign q_push     = acc & (in_mode | page_end);
  assign q_ev.start = in_mode;
  assign q_ev.good  = ({in_data_byte, lowb_r} == crc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      wait_r   <= 1'b0;
      cnt_r    <= '0;
      crc_r    <= '0;
      lowb_r   <= '0;
    end else begin
      if (resp.valid) begin
        wait_r   <= 1'b0;
        active_r <= resp.active;
      end
      if (acc) begin
        if (in_mode) begin
          active_r <= 1'b1;
          cnt_r    <= '0;
          crc_r    <= '0;
          lowb_r   <= '0;
        end else if (active_r) begin
          if (cnt_r < CNT_W'(PAGE_BYTES)) begin
            crc_r <= crc_update(crc_r, in_data_byte);
            cnt_r <= cnt_r + CNT_W'(1);
          end else if (cnt_r == CNT_W'(PAGE_BYTES)) begin
            lowb_r <= in_data_byte;
            cnt_r  <= cnt_r + CNT_W'(1);
          end else begin
            // last CRC byte: hold input until the sequencer decides
            cnt_r  <= '0;
            crc_r  <= '0;
            lowb_r <= '0;
            wait_r <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/crcpr_back.sv =====
// Page sequencer: failure map, retransmit search and the result register.
module crcpr_back
  import crcpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LIM_W-1:0] total_pages,
  input  logic             q_empty,
  input  ev_t              q_ev,
  output logic             q_pop,
  output resp_t            resp,
  output logic             out_valid,
  input  logic             out_stall,
  output res_t             out_res
);

  typedef enum logic [1:0] {ST_WAIT, ST_SEARCH, ST_EMIT2} st_t;
  typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_RETRY, PH_DONE} phase_t;

  st_t              st_r;
  phase_t           phase_r;
  logic [PG_W-1:0]  cur_r;
  logic [MAX_PAGES-1:0] failed_r;
  logic [LIM_W-1:0] from_r;
  logic [GRP_W-1:0] grp_r;
  res_t             hold_r;
  res_t             out_res_r;
  logic             out_valid_r;
  resp_t            resp_r;

  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] cur_inc;
  logic             out_free;
  logic [GRP_SZ-1:0] hit;
  logic             found;
  logic [OFF_W-1:0] pos;
  logic [LIM_W-1:0] nb;
  logic             last_grp;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign resp      = resp_r;

  always_comb begin
    if (total_pages == '0) begin
      lim = LIM_W'(1);
    end else if (total_pages > LIM_W'(MAX_PAGES)) begin
      lim = LIM_W'(MAX_PAGES);
    end else begin
      lim = total_pages;
    end
  end

  assign cur_inc  = LIM_W'(cur_r) + LIM_W'(1);
  assign out_free = ~out_valid_r | ~out_stall;
  assign q_pop    = (st_r == ST_WAIT) & ~q_empty & (q_ev.start | out_free);

  // one group of the failure map per cycle
  always_comb begin
    for (int k = 0; k < GRP_SZ; k++) begin
      hit[k] = failed_r[{grp_r, OFF_W'(k)}]
             & (LIM_W'({grp_r, OFF_W'(k)}) >= from_r)
             & (LIM_W'({grp_r, OFF_W'(k)}) < lim);
    end
    pos = '0;
    for (int k = GRP_SZ - 1; k >= 0; k--) begin
      if (hit[k]) begin
        pos = OFF_W'(k);
      end
    end
  end

  assign found    = |hit;
  assign nb       = LIM_W'({grp_r, OFF_W'(0)}) + LIM_W'(GRP_SZ);
  assign last_grp = (nb >= lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_WAIT;
      phase_r     <= PH_IDLE;
      cur_r       <= '0;
      failed_r    <= '0;
      from_r      <= '0;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
      resp_r      <= '0;
    end else begin
      resp_r.valid <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_WAIT: begin
          if (q_pop) begin
            if (q_ev.start) begin
              failed_r <= '0;
              phase_r  <= PH_FIRST;
              cur_r    <= '0;
            end else if (phase_r == PH_FIRST) begin
              if (!q_ev.good) begin
                failed_r[cur_r] <= 1'b1;
              end
              out_valid_r    <= 1'b1;
              out_res_r.kind <= q_ev.good ? K_OK : K_BAD;
              out_res_r.page <= cur_r;
              if (cur_inc < lim) begin
                out_res_r.last <= 1'b1;
                cur_r          <= cur_inc[PG_W-1:0];
                resp_r         <= '{valid: 1'b1, active: 1'b1};
              end else begin
                out_res_r.last <= 1'b0;
                from_r         <= '0;
                grp_r          <= '0;
                st_r           <= ST_SEARCH;
              end
            end else begin
              out_valid_r    <= 1'b1;
              out_res_r.page <= cur_r;
              out_res_r.last <= 1'b0;
              if (!q_ev.good) begin
                out_res_r.kind <= K_BAD;
                hold_r         <= '{kind: K_REQ, page: cur_r, last: 1'b1};
                resp_r         <= '{valid: 1'b1, active: 1'b1};
                st_r           <= ST_EMIT2;
              end else begin
                out_res_r.kind  <= K_OK;
                failed_r[cur_r] <= 1'b0;
                from_r          <= cur_inc;
                grp_r           <= cur_inc[PG_W-1:OFF_W];
                st_r            <= ST_SEARCH;
              end
            end
          end
        end
        ST_SEARCH: begin
          if (found) begin
            phase_r <= PH_RETRY;
            cur_r   <= {grp_r, pos};
            hold_r  <= '{kind: K_REQ, page: {grp_r, pos}, last: 1'b1};
            resp_r  <= '{valid: 1'b1, active: 1'b1};
            st_r    <= ST_EMIT2;
          end else if (last_grp) begin
            phase_r <= PH_DONE;
            cur_r   <= '0;
            hold_r  <= '{kind: K_DONE, page: '0, last: 1'b1};
            resp_r  <= '{valid: 1'b1, active: 1'b0};
            st_r    <= ST_EMIT2;
          end else begin
            grp_r <= grp_r + GRP_W'(1);
          end
        end
        ST_EMIT2: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_res_r   <= hold_r;
            st_r        <= ST_WAIT;
          end
        end
        default: st_r <= ST_WAIT;
      endcase
    end
  end

endmodule

// ===== rtl/crc_checked_page_receiver.sv =====
// Top level of the CRC-checked page receiver.
// An image arrives as total_pages pages of 512 data bytes, each followed by
// its CRC-16/XMODEM (poly 0x1021, init 0), low byte first. in_mode = 1 starts
// a new transfer and clears the failure map; data bytes outside a transfer
// are taken and dropped. The last CRC byte of each page yields an ok/bad
// verdict transaction. After the first pass every failed page is requested
// in ascending order (a retransmit request transaction), and a page that
// fails again is requested again; when none is left a done transaction
// follows. out_last marks the final result caused by one input byte.
// Rate: one byte per clock when in_stall is low. At each page end the input
// stalls while the sequencer decides, and longer when the failure map is
// scanned (8 map bits per cycle, 64 pages). A held result under out_stall
// lengthens the page-end stall. The front end (CRC, byte count) and the
// sequencer (failure map, search, result register) are split by a two-entry
// event queue. total_pages of 0 counts as 1, above 64 as 64; write it only
// while no transaction is pending.
module crc_checked_page_receiver
  import crcpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [LIM_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [PG_W-1:0]      out_page_index,
  output logic                 out_last
);

  logic [LIM_W-1:0] total_pages_r;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  ev_t              push_ev;
  ev_t              pop_ev;
  resp_t            resp;
  res_t             res;

  // page-count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_pages_r <= TP_RESET;
    end else if (cfg_we) begin
      total_pages_r <= cfg_wdata;
    end
  end

  crcpr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_ev         (push_ev),
    .resp         (resp)
  );

  crcpr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_ev (push_ev),
    .full    (q_full),
    .pop     (q_pop),
    .pop_ev  (pop_ev),
    .empty   (q_empty)
  );

  crcpr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .total_pages (total_pages_r),
    .q_empty     (q_empty),
    .q_ev        (pop_ev),
    .q_pop       (q_pop),
    .resp        (resp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (res)
  );

  assign out_kind       = res.kind;
  assign out_page_index = res.page;
  assign out_last       = res.last;

endmodule

// ===== rtl/crcpr_checker.sv =====
// Port-level checker for the page receiver, bound to the top level.
`include "crc_checked_page_receiver_assert.svh"

module crcpr_checker
  import crcpr_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_mode,
  input logic [7:0]           in_data_byte,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [1:0]           out_kind,
  input logic [PG_W-1:0]      out_page_index,
  input logic                 out_last
);

  // stalled input transaction holds
  `CPR_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
    in_valid && $stable(in_mode) && $stable(in_data_byte),
    "stalled input changed")

  // stalled result transaction holds
  `CPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_kind) && $stable(out_page_index) && $stable(out_last),
    "stalled result changed")

  // done ends a byte's results and names page zero
  `CPR_ASSERT_NOW(a_done_form, clk, rst_n, out_valid && (out_kind == K_DONE),
    out_last && (out_page_index == '0), "malformed done")

  // a retransmit request is always the final result of its byte
  `CPR_ASSERT_NOW(a_req_last, clk, rst_n, out_valid && (out_kind == K_REQ),
    out_last, "request not marked last")

  // only a verdict can be followed by a second result
  `CPR_ASSERT_NOW(a_first_is_verdict, clk, rst_n, out_valid && !out_last,
    (out_kind == K_OK) || (out_kind == K_BAD), "non-last result is not a verdict")

endmodule

bind crc_checked_page_receiver crcpr_checker u_chk (.*);
